// ===== sv/mavg_pkg.sv =====
// Shared types and constants of the moving average filter.
// No dependencies; every other file of the block imports this package.
package mavg_pkg;

  // Width of the window length register and of the configuration word.
  localparam int LEN_W = 9;

  // Default parameter values and reset window length.
  localparam int MAX_LENGTH_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int LEN_RESET       = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // capture the input word and read the sample leaving the window
    logic update;    // update sum and ring, start the divider
    logic load_out;  // load the quotient into the output register
  } mavg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
  } mavg_stat_t;

endpackage

// ===== sv/moving_average_filter_core.sv =====
// Top level of the boxcar moving average filter: controller plus datapath.
// Depends on mavg_pkg, mavg_ctrl, mavg_datapath (and through it mavg_divider).
//
//   Channel   Direction  Handshake              Payload
//   in_       slave      in_tvalid/in_tready    sample (signed)
//   out_      master     out_tvalid/out_tready  average (signed)
//   cfg_      write      cfg_wr_en              window_length (9 bits)
//
// Each word passes from acceptance through the update of ring and sum and
// through the shared divider, which produces one quotient bit per cycle,
// until its result is loaded. Reset is synchronous and active low; it sets
// the window length to 8 and empties the history. The ring needs no clearing
// pass: a fill count marks which entries hold samples, and older ones read
// as zero.
// The output register lets the next input word be accepted while a result
// waits; a stalled output only holds the following result back at load time.
module moving_average_filter_core import mavg_pkg::*; #(
  parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: sample.
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0: average, then zero fill.
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [LEN_W-1:0]                    cfg_wr_data
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  mavg_cmd_t              cmd;
  mavg_stat_t             stat;
  logic [SAMPLE_BITS-1:0] average;

  // The controller only sequences; all storage and arithmetic sit in the datapath.
  mavg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mavg_datapath #(
    .MAX_LENGTH  (MAX_LENGTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_sample   (in_tdata[SAMPLE_BITS-1:0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_average (average)
  );

  assign out_tdata = TDATA_W'(average);

  // Only one word is in flight: an accepted word closes the input until it is done.
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a word is still in work");

  // A result that has not been taken must never be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("output register loaded over a pending result");

  // Accept, update and output load are distinct steps of the sequence.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.update, cmd.load_out}))
    else $error("controller issued overlapping commands");

  // The divider reports completion only while the controller waits for it or after.
  a_update_then_divide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> !stat.div_done)
    else $error("divider done flag not cleared by start");

endmodule

// ===== sv/mavg_divider.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Depends on mavg_pkg for the divisor width.
module mavg_divider import mavg_pkg::*; #(
  parameter int SUM_W       = 24,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [SUM_W-1:0]       dividend,
  input  logic        [LEN_W-1:0]       divisor,
  output logic                          done,
  output logic        [SAMPLE_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r;
  logic [SUM_W-1:0] q_r, q_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] div_r;
  logic [LEN_W:0]   rem_sh;
  logic [SUM_W-1:0] q_signed;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    rem_sh   = {rem_r, q_r[SUM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CNT_W'(SUM_W);
      rem_nxt  = '0;
      // Work on the magnitude; the sign is restored at the end (truncation toward zero).
      q_nxt    = dividend[SUM_W-1] ? (-dividend) : dividend;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, div_r}) begin
        rem_nxt = LEN_W'(rem_sh - {1'b0, div_r});
        q_nxt   = {q_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[LEN_W-1:0];
        q_nxt   = {q_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      div_r <= divisor;
    end
  end

  assign q_signed = neg_r ? (-q_r) : q_r;
  assign quotient = q_signed[SAMPLE_BITS-1:0];
  assign done     = done_r;

endmodule

// ===== sv/mavg_datapath.sv =====
// Datapath of the moving average filter: sample ring, running sum,
// window length register and output register. Depends on mavg_pkg and mavg_divider.
module mavg_datapath import mavg_pkg::*; #(
  parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mavg_cmd_t              cmd,
  output mavg_stat_t             stat,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   cfg_wr_en,
  input  logic [LEN_W-1:0]       cfg_wr_data,
  output logic [SAMPLE_BITS-1:0] out_average
);

  localparam int PTR_W = $clog2(MAX_LENGTH);
  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam int EXT_W = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_LENGTH);
  localparam int LEN_INIT = (LEN_RESET > MAX_LENGTH) ? MAX_LENGTH : LEN_RESET;

  logic [SAMPLE_BITS-1:0] ring_r [MAX_LENGTH];

  logic [LEN_W-1:0]              len_r, len_nxt;
  logic [PTR_W-1:0]              pos_r, pos_nxt;
  logic [CNT_W-1:0]              fill_r, fill_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0]        rd_data_r;
  logic                          old_valid_r;
  logic [EXT_W-1:0]              pos_e, len_e, old_e;
  logic [PTR_W-1:0]              old_idx;
  logic                          old_valid;
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic [SAMPLE_BITS-1:0]        quotient;
  logic [SAMPLE_BITS-1:0]        avg_r;

  // Index of the sample that leaves the window: (pos - len) modulo the ring depth.
  always_comb begin
    pos_e = EXT_W'(pos_r);
    len_e = EXT_W'(len_r);
    if (pos_e >= len_e) begin
      old_e = pos_e - len_e;
    end else begin
      old_e = pos_e + EXT_W'(MAX_LENGTH) - len_e;
    end
    old_idx = old_e[PTR_W-1:0];
    // Entries are written in order from zero after a clear, so an entry
    // below the fill count holds a real sample and any other reads as zero.
    old_valid = (32'(old_e) < 32'(fill_r));
  end

  assign old_sample = old_valid_r ? $signed(rd_data_r) : '0;

  always_comb begin
    len_nxt  = len_r;
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (cmd.update) begin
      sum_nxt = sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);
      pos_nxt = (32'(pos_r) == MAX_LENGTH - 1) ? '0 : pos_r + 1'b1;
      if (32'(fill_r) < MAX_LENGTH) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        len_nxt = LEN_W'(1);
      end else if (32'(cfg_wr_data) > MAX_LENGTH) begin
        len_nxt = LEN_W'(MAX_LENGTH);
      end else begin
        len_nxt = cfg_wr_data;
      end
      pos_nxt  = '0;
      fill_nxt = '0;
      sum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= LEN_W'(LEN_INIT);
      pos_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      len_r  <= len_nxt;
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // Ring memory: one registered read at accept, one write at update.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data_r <= ring_r[old_idx];
    end
    if (cmd.update) begin
      ring_r[pos_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r    <= $signed(in_sample);
      old_valid_r <= old_valid;
    end
    if (cmd.load_out) begin
      avg_r <= quotient;
    end
  end

  mavg_divider #(
    .SUM_W       (SUM_W),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.update),
    .dividend (sum_nxt),
    .divisor  (len_r),
    .done     (stat.div_done),
    .quotient (quotient)
  );

  assign out_average = avg_r;

endmodule

// ===== sv/mavg_ctrl.sv =====
// Controller of the moving average filter: sequences one word through
// accept, update, divide and output load. Depends on mavg_pkg.
module mavg_ctrl import mavg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  mavg_stat_t stat,
  output mavg_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIVIDE,
    S_OUTPUT
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_tready    = (state_r == S_IDLE);
  assign cmd.accept   = in_tvalid && (state_r == S_IDLE);
  assign cmd.update   = (state_r == S_UPDATE);
  assign cmd.load_out = (state_r == S_OUTPUT) && (!out_valid_r || out_tready);
  assign out_tvalid   = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // A load refills the output register in the same cycle that the old word leaves.
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state_r <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (stat.div_done) begin
            state_r <= S_OUTPUT;
          end
        end
        S_OUTPUT: begin
          if (!out_valid_r || out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
